>>> sv/fpba_pkg.sv
// Shared types, codes and defaults of the fit policy block allocator.
`timescale 1ns / 1ps

package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam int SLOT_W   = 4;
    localparam int REQ_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [1:0] {
        POLICY_FIRST = 2'd0,
        POLICY_BEST  = 2'd1,
        POLICY_WORST = 2'd2,
        POLICY_NEXT  = 2'd3
    } t_policy;

    localparam logic [STATUS_W-1:0] STATUS_ALLOC  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    // Control from the scan sequencer to the candidate tracker.
    typedef struct packed {
        logic    clear;
        logic    sample;
        t_policy policy;
    } t_pick_ctl;

endpackage

>>> sv/fpba_pick.sv
// Candidate tracker: keeps the best block seen so far during a table scan.
`timescale 1ns / 1ps

module fpba_pick #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpba_pkg::t_pick_ctl           i_ctl,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_idx,
    input  logic [SIZE_WIDTH-1:0]         i_size,
    input  logic [SIZE_WIDTH-1:0]         i_need,
    output logic                          o_found,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_idx,
    output logic [SIZE_WIDTH-1:0]         o_size
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic [SIZE_WIDTH-1:0] r_size;
    logic             w_fits;
    logic             w_better;
    logic             w_take;

    // Entries arrive in scan order, so the first fitting entry wins unless
    // the policy prefers a strictly smaller or strictly larger block.
    always_comb begin
        w_fits   = (i_size >= i_need);
        w_better = !r_found
                || ((i_ctl.policy == fpba_pkg::POLICY_BEST)  && (i_size < r_size))
                || ((i_ctl.policy == fpba_pkg::POLICY_WORST) && (i_size > r_size));
        w_take   = i_ctl.sample && w_fits && w_better;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
        if (w_take && !i_ctl.clear) begin
            r_idx  <= i_idx;
            r_size <= i_size;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_size  = r_size;

endmodule

>>> sv/fit_policy_block_allocator.sv
// Top level of the fit policy block allocator: table memory and scan sequencer.
`timescale 1ns / 1ps
// A load word goes from the idle state to the push state and into the output register;
// an allocate word goes through the scan, drain, apply and push states (idle straight to
// apply when no blocks are in use). The input stays stalled until the result enters the
// output register, so a new word waits for the last; the scan reads one table entry per cycle.
// Reset is synchronous and active low; it clears the sequencer, the next-fit
// pointer and the registers, while the table stays undefined until loaded.

module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input word channel.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_command,
    input  logic [fpba_pkg::SLOT_W-1:0]       i_block_slot,
    input  logic [fpba_pkg::REQ_W-1:0]        i_request_size,
    input  logic                              i_last_request,
    // Result word channel.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [fpba_pkg::STATUS_W-1:0]     o_status,
    output logic [fpba_pkg::SLOT_W-1:0]       o_chosen_block,
    output logic [fpba_pkg::REQ_W-1:0]        o_remaining_size,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = fpba_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_APPLY,
        S_PUSH
    } t_state;

    t_state r_state;

    // Configuration registers.
    fpba_pkg::t_policy r_fit_policy;
    logic [CNT_W-1:0]  r_block_count;

    // Free size table, one entry per block, with a registered read port.
    logic [SIZE_WIDTH-1:0] r_mem [NUM_BLOCKS];
    logic [SIZE_WIDTH-1:0] r_rd_data;
    logic                  w_mem_we;
    logic [IDX_W-1:0]      w_mem_waddr;
    logic [SIZE_WIDTH-1:0] w_mem_wdata;

    // Scan sequencer.
    logic [IDX_W-1:0]      r_addr;
    logic [CNT_W-1:0]      r_step;
    logic [CNT_W-1:0]      r_n;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [SIZE_WIDTH-1:0] r_need;
    logic                  r_last;
    logic [IDX_W-1:0]      r_scan_ptr;

    // Pending result, waiting for the output register.
    logic [fpba_pkg::STATUS_W-1:0] r_res_status;
    logic [fpba_pkg::SLOT_W-1:0]   r_res_block;
    logic [fpba_pkg::REQ_W-1:0]    r_res_size;

    // Output register.
    logic                          r_out_valid;
    logic [fpba_pkg::STATUS_W-1:0] r_out_status;
    logic [fpba_pkg::SLOT_W-1:0]   r_out_block;
    logic [fpba_pkg::REQ_W-1:0]    r_out_size;

    logic                  w_accept;
    logic                  w_out_free;
    logic [CNT_W-1:0]      w_n;
    logic [IDX_W-1:0]      w_start;
    logic [IDX_W-1:0]      w_addr_next;
    logic [SIZE_WIDTH-1:0] w_size_in;
    logic                  w_slot_ok;
    logic [SIZE_WIDTH-1:0] w_left;

    fpba_pkg::t_pick_ctl   w_pick_ctl;
    logic                  w_pick_found;
    logic [IDX_W-1:0]      w_pick_idx;
    logic [SIZE_WIDTH-1:0] w_pick_size;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;

    always_comb begin
        // The count in use never exceeds the table depth.
        w_n = (32'(r_block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : r_block_count;
        // Next fit resumes at the pointer when it still lies inside the blocks
        // in use; every other policy scans from the bottom of the table.
        if ((r_fit_policy == fpba_pkg::POLICY_NEXT) && (32'(r_scan_ptr) < 32'(w_n))) begin
            w_start = r_scan_ptr;
        end else begin
            w_start = '0;
        end
        w_addr_next = (32'(r_addr) + 32'd1 == 32'(r_n)) ? '0 : IDX_W'(32'(r_addr) + 32'd1);
        w_size_in   = SIZE_WIDTH'(i_request_size);
        w_slot_ok   = (32'(i_block_slot) < NUM_BLOCKS);
        w_left      = w_pick_size - r_need;
    end

    // Table writes come from a load in idle or from the write-back of an
    // allocate; the two never coincide because only one word is in flight.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = w_left;
        if (w_accept && (i_command == 1'b0) && w_slot_ok) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = IDX_W'(i_block_slot);
            w_mem_wdata = w_size_in;
        end else if ((r_state == S_APPLY) && w_pick_found) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = w_pick_idx;
            w_mem_wdata = w_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_comb begin
        w_pick_ctl.clear  = w_accept;
        w_pick_ctl.sample = r_rd_vld;
        w_pick_ctl.policy = r_fit_policy;
    end

    fpba_pick #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_pick_ctl),
        .i_idx   (r_rd_idx),
        .i_size  (r_rd_data),
        .i_need  (r_need),
        .o_found (w_pick_found),
        .o_idx   (w_pick_idx),
        .o_size  (w_pick_size)
    );

    // Sequencer, configuration and output register. A read issued in the
    // scan state returns its data in the next cycle, tagged by r_rd_vld and
    // r_rd_idx, and the tracker samples it then. The final entry is judged
    // in the drain state, so the candidate is settled by the apply state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fit_policy  <= fpba_pkg::POLICY_FIRST;
            r_block_count <= fpba_pkg::BLOCK_COUNT_RST;
            r_scan_ptr    <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            r_rd_idx <= r_addr;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fpba_pkg::REG_FIT_POLICY: begin
                        r_fit_policy <= fpba_pkg::t_policy'(i_cfg_data[1:0]);
                    end
                    fpba_pkg::REG_BLOCK_COUNT: begin
                        r_block_count <= i_cfg_data[CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_need <= w_size_in;
                        r_last <= i_last_request;
                        r_n    <= w_n;
                        r_addr <= w_start;
                        r_step <= '0;
                        if (i_command == 1'b0) begin
                            r_res_status <= fpba_pkg::STATUS_LOADED;
                            r_res_block  <= '0;
                            r_res_size   <= fpba_pkg::REQ_W'(w_size_in);
                            r_state      <= S_PUSH;
                        end else if (w_n == '0) begin
                            r_state <= S_APPLY;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_addr <= w_addr_next;
                    r_step <= r_step + CNT_W'(1);
                    if (r_step + CNT_W'(1) == r_n) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_pick_found) begin
                        r_res_status <= fpba_pkg::STATUS_ALLOC;
                        r_res_block  <= fpba_pkg::SLOT_W'(w_pick_idx);
                        r_res_size   <= fpba_pkg::REQ_W'(w_left);
                    end else begin
                        r_res_status <= fpba_pkg::STATUS_NONE;
                        r_res_block  <= '0;
                        r_res_size   <= '0;
                    end
                    // The last word of a batch rewinds the pointer under any policy.
                    if (r_last) begin
                        r_scan_ptr <= '0;
                    end else if (w_pick_found && (r_fit_policy == fpba_pkg::POLICY_NEXT)) begin
                        r_scan_ptr <= w_pick_idx;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if ((r_state == S_PUSH) && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_block  <= r_res_block;
                r_out_size   <= r_res_size;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_chosen_block   = r_out_block;
    assign o_remaining_size = r_out_size;

    // Only one word is in flight: an accepted word closes the input at once.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("input accepted while a word was in flight");

    // The table is never written while a scan is reading it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_LAST) |-> !w_mem_we)
        else $error("table written during a scan");

    // A chosen block always holds at least the requested size.
    a_pick_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && w_pick_found) |-> (w_pick_size >= r_need))
        else $error("chosen block is smaller than the request");

    // Every returned read lies inside the blocks in use.
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (32'(r_rd_idx) < 32'(r_n)))
        else $error("scan read outside the blocks in use");

    // The drain state always comes in the cycle after the final scan read.
    a_drain_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |-> $past(r_state == S_SCAN))
        else $error("drain state entered without a scan");

endmodule
